// ----- rtl/otq_pkg.sv -----
`default_nettype none
package otq_pkg;
  localparam int NumSlots = 16;
  localparam int SlotW = 4;

  typedef enum logic [1:0] {
    CmdSet    = 2'd0,
    CmdCancel = 2'd1,
    CmdTick   = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StSetFire,
    StScan,
    StPick,
    StFire1,
    StFire2,
    StRearm,
    StClose
  } state_e;

  typedef struct packed {
    logic            fired;
    logic [SlotW-1:0] slot;
    logic            last;
  } res_t;
endpackage
`default_nettype wire

// ----- rtl/otq_ram.sv -----
`default_nettype none
module otq_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/otq_scan.sv -----
`default_nettype none
// Running best-candidate compare: one slot offered per cycle.
module otq_scan
  import otq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             en_i,
  input  wire logic [SlotW-1:0] idx_i,
  input  wire logic [63:0]      due_i,
  input  wire logic [31:0]      age_i,
  output logic                  found_o,
  output logic [SlotW-1:0]      best_o,
  output logic [63:0]           best_due_o
);
  logic found_q, found_d;
  logic [SlotW-1:0] best_q, best_d;
  logic [63:0] due_q, due_d;
  logic [31:0] age_q, age_d;
  logic better;

  assign better = !found_q || (due_i < due_q) || ((due_i == due_q) && (age_i > age_q));

  always_comb begin
    found_d = found_q;
    best_d = best_q;
    due_d = due_q;
    age_d = age_q;
    if (start_i) begin
      found_d = 1'b0;
    end else if (en_i && better) begin
      found_d = 1'b1;
      best_d = idx_i;
      due_d = due_i;
      age_d = age_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) found_q <= 1'b0;
    else found_q <= found_d;
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    due_q <= due_d;
    age_q <= age_d;
  end

  assign found_o = found_q;
  assign best_o = best_q;
  assign best_due_o = due_q;
endmodule
`default_nettype wire

// ----- rtl/ordered_timer_queue_unit.sv -----
`default_nettype none
// Ordered timer queue with 16 slots and a 64-bit system time.
// s_axis: tdata = {amount[63:0], is_periodic, slot[3:0], cmd[1:0]} (71 bits, 72 wide).
// cfg: cfg_valid_i/cfg_ready_o/cfg_data_i writes default_period (reset 1); write idle only.
// m_axis: tdata = {now[63:0], fired_slot[3:0], fired} (69 bits, 72 wide), tlast = last.
// Each input gives its firings then one closing result with tlast high.
// The block takes one transaction at a time; s_axis_tready is high only when idle.
// Set passes through a write step before its output; cancel goes straight to
// the closing result. Tick: one scan of the slots (one slot through the shared
// compare per cycle) per slot fired plus a fire and a re-arm step, a second
// fire step per double firing, then one final empty scan and the closing result.
// Per-slot times live in small RAMs with registered read, which set the
// one-slot-per-cycle scan pace.
// A stalled m_axis holds its result; the sequencer waits before giving another.
// Reset: time 0, all slots disarmed, order counter 0, default period 1.
module ordered_timer_queue_unit
  import otq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // cmd, slot, is_periodic, amount
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // fired, fired_slot, now
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] cfg_data_i
);
  state_e state_q, state_d;
  logic [63:0] now_q, now_d, dper_q;
  logic [31:0] ord_q, ord_d;
  logic [NumSlots-1:0] armed_q, armed_d, done_q, done_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic per_q;
  logic [63:0] amt_q;
  logic [SlotW:0] cnt_q, cnt_d;
  logic ovld_q, ovld_d;
  res_t ores_q, ores_d;
  logic [63:0] onow_q;
  logic [63:0] nd_q, nd_d;

  // RAM ports
  logic due_we, per_we;
  logic [SlotW-1:0] waddr, raddr;
  logic [63:0] due_wd, per_wd, due_rd, per_rd;
  logic [31:0] ins_wd, ins_rd;
  logic rd_vld_q;
  logic [SlotW-1:0] rd_idx_q;
  logic scan_start, scan_en, found;
  logic [SlotW-1:0] best;
  logic [63:0] best_due, set_delay;

  otq_ram #(.Width(64), .Depth(NumSlots)) u_due (.clk_i, .we_i(due_we), .waddr_i(waddr),
    .wdata_i(due_wd), .raddr_i(raddr), .rdata_o(due_rd));
  otq_ram #(.Width(64), .Depth(NumSlots)) u_per (.clk_i, .we_i(per_we), .waddr_i(waddr),
    .wdata_i(per_wd), .raddr_i(raddr), .rdata_o(per_rd));
  otq_ram #(.Width(32), .Depth(NumSlots)) u_ins (.clk_i, .we_i(due_we), .waddr_i(waddr),
    .wdata_i(ins_wd), .raddr_i(raddr), .rdata_o(ins_rd));

  assign scan_en = rd_vld_q && armed_q[rd_idx_q] && !done_q[rd_idx_q] && (due_rd <= now_q);

  otq_scan u_scan (.clk_i, .rst_ni, .start_i(scan_start), .en_i(scan_en), .idx_i(rd_idx_q),
    .due_i(due_rd), .age_i(ord_q - ins_rd), .found_o(found), .best_o(best),
    .best_due_o(best_due));

  assign set_delay = (per_q && (amt_q == 64'd0)) ? dper_q : amt_q;
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == StIdle);

  logic ostall;
  assign ostall = ovld_q && !m_axis_tready;

  always_comb begin
    state_d = state_q;
    now_d = now_q;
    ord_d = ord_q;
    armed_d = armed_q;
    done_d = done_q;
    slot_d = slot_q;
    cnt_d = cnt_q;
    ovld_d = ovld_q && !m_axis_tready;
    ores_d = ores_q;
    nd_d = nd_q;
    due_we = 1'b0;
    per_we = 1'b0;
    waddr = slot_q;
    due_wd = nd_q;
    per_wd = 64'd0;
    ins_wd = ord_q;
    raddr = cnt_q[SlotW-1:0];
    scan_start = 1'b0;
    unique case (state_q)
      StIdle: begin
        raddr = best;
        if (s_axis_tvalid) begin
          slot_d = s_axis_tdata[5:2];
          state_d = StClose;
          unique case (cmd_e'(s_axis_tdata[1:0]))
            CmdSet: state_d = StSetFire;
            CmdCancel: armed_d[s_axis_tdata[5:2]] = 1'b0;
            CmdTick: begin
              now_d = now_q + s_axis_tdata[70:7];
              done_d = '0;
              cnt_d = '0;
              scan_start = 1'b1;
              state_d = StScan;
            end
            CmdNone: ;
            default: ;
          endcase
        end
      end
      StSetFire: begin
        if (!ostall) begin
          due_we = 1'b1;
          per_we = 1'b1;
          due_wd = now_q + set_delay;
          per_wd = per_q ? set_delay : 64'd0;
          armed_d[slot_q] = 1'b1;
          ord_d = ord_q + 32'd1;
          if (set_delay == 64'd0) begin
            ovld_d = 1'b1;
            ores_d = '{fired: 1'b1, slot: slot_q, last: 1'b0};
          end
          state_d = StClose;
        end
      end
      StScan: begin
        if (cnt_q == SlotW'(0) + (SlotW+1)'(NumSlots)) state_d = StPick;
        else cnt_d = cnt_q + 1'b1;
      end
      StPick: begin
        raddr = best;
        if (!found) state_d = StClose;
        else state_d = StFire1;
      end
      StFire1: begin
        raddr = best;
        if (!ostall) begin
          slot_d = best;
          done_d[best] = 1'b1;
          ovld_d = 1'b1;
          ores_d = '{fired: 1'b1, slot: best, last: 1'b0};
          nd_d = best_due + per_rd;
          if (per_rd == 64'd0) begin
            armed_d[best] = 1'b0;
            state_d = StRearm;
          end else if (best_due + per_rd <= now_q) begin
            nd_d = now_q + per_rd;
            state_d = StFire2;
          end else begin
            state_d = StRearm;
          end
        end
      end
      StFire2: begin
        if (!ostall) begin
          ovld_d = 1'b1;
          ores_d = '{fired: 1'b1, slot: slot_q, last: 1'b0};
          state_d = StRearm;
        end
      end
      StRearm: begin
        if (armed_q[slot_q]) begin
          due_we = 1'b1;
          ord_d = ord_q + 32'd1;
        end
        cnt_d = '0;
        scan_start = 1'b1;
        state_d = StScan;
      end
      StClose: begin
        if (!ostall) begin
          ovld_d = 1'b1;
          ores_d = '{fired: 1'b0, slot: '0, last: 1'b1};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      now_q <= '0;
      ord_q <= '0;
      armed_q <= '0;
      done_q <= '0;
      cnt_q <= '0;
      ovld_q <= 1'b0;
      dper_q <= 64'd1;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q <= now_d;
      ord_q <= ord_d;
      armed_q <= armed_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      ovld_q <= ovld_d;
      rd_vld_q <= (state_q == StScan) && (cnt_q < (SlotW+1)'(NumSlots));
      if (cfg_valid_i) dper_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    ores_q <= ores_d;
    nd_q <= nd_d;
    rd_idx_q <= raddr;
    // time is captured with the result so a waiting result keeps it
    if (ovld_d && !ostall) onow_q <= now_q;
    if (s_axis_tvalid && s_axis_tready) begin
      per_q <= s_axis_tdata[6];
      amt_q <= s_axis_tdata[70:7];
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {3'd0, onow_q, ores_q.slot, ores_q.fired};
  assign m_axis_tlast = ores_q.last;
endmodule
`default_nettype wire

// ----- rtl/otq_checker.sv -----
`default_nettype none
module otq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[0])
    else $error("closing result marked fired");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted while busy");
endmodule

bind ordered_timer_queue_unit otq_checker u_otq_checker (.*);
`default_nettype wire
